// ----- sv/wme_pkg.sv -----
// Package for the waveform min/max envelope block: register map, widths and
// the small structs passed between the update, storage and drain modules.
// Depends on nothing; every other file of the block imports it.
package wme_pkg;

   // Fixed widths of the register and result fields.
   localparam int COUNT_REG_BITS  = 4;
   localparam int BUCKET_REG_BITS = 16;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;
   localparam int OUT_FRAME_BITS  = 32;
   localparam int OUT_CHAN_BITS   = 3;

   // Register reset values.
   localparam logic [COUNT_REG_BITS-1:0]  CHANNEL_COUNT_RESET = 4'd1;
   localparam logic [BUCKET_REG_BITS-1:0] BUCKET_SIZE_RESET   = 16'd256;

   // Register index, taken from the word address of the request.
   typedef enum logic {
      REG_CHANNEL_COUNT      = 1'b0,
      REG_SAMPLES_PER_BUCKET = 1'b1
   } csr_index_type;

   // A bucket has closed: which bank holds it and what goes with its results.
   typedef struct packed {
      logic                      valid;
      logic                      bank;
      logic                      eos;
      logic [OUT_FRAME_BITS-1:0] frame;
   } close_event_type;

   // Drain has finished with a bank: forget every entry in it.
   typedef struct packed {
      logic clear;
      logic bank;
   } bank_clear_type;

endpackage

// ----- sv/waveform_minmax_envelope.sv -----
// Min/max peak envelope over an interleaved multi-channel sample stream.
// Each request carries one Q1.15 sample, channels in order, and a flag on the
// last sample of the stream. Per channel a running minimum and maximum is kept
// over buckets of samples_per_bucket frames. When a bucket fills, or the stream
// ends, one result per channel follows in channel order with the bucket's start
// frame; the stream end also returns the frame count to zero.
// Throughput: one request per cycle, except when the bank that the request
// side moves on to is still draining, as with one-frame buckets. The
// accumulators sit in a two-bank memory, read through a registered port and
// written back by the read-modify-write stage, forwarding between neighbours.
// Once the closing request leaves the read-modify-write stage, its bank is
// marked busy and drained, one result per cycle while rsp_stall is low.
// One bank drains while the other collects the next bucket; the request side
// stalls whenever the bank it moves on to is still draining. Results come
// straight from the memory's drain read register, held while rsp_stall is high.
// Settings go through the register port (channel count at 0x0, bucket size at
// 0x4); the user changes them only while the block is idle; the block does not
// enforce this. Synchronous reset restores the register defaults, empties both
// banks at once through per-entry seen bits, and starts a new stream at frame zero.
module waveform_minmax_envelope #(
   parameter int MAX_CHANNELS     = 8,
   parameter int SAMPLE_BITS      = 16,
   parameter int FRAME_COUNT_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request channel.
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   input  logic                                 req_last_sample,
   // Result channel.
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wme_pkg::OUT_CHAN_BITS-1:0]    rsp_channel,
   output logic [wme_pkg::OUT_FRAME_BITS-1:0]   rsp_bucket_start_frame,
   output logic signed [SAMPLE_BITS-1:0]        rsp_min_value,
   output logic signed [SAMPLE_BITS-1:0]        rsp_max_value,
   output logic                                 rsp_last_of_run,
   output logic                                 rsp_end_of_stream,
   // Register port.
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wme_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [wme_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [wme_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import wme_pkg::*;

   localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_BITS = $clog2(MAX_CHANNELS+1);

   logic [COUNT_REG_BITS-1:0]  channel_count_ff, channel_count_in;
   logic [BUCKET_REG_BITS-1:0] bucket_reg_ff, bucket_reg_in;
   logic                       csr_write;
   csr_index_type              csr_index;

   logic [CNT_BITS-1:0]        active_count;
   logic [BUCKET_REG_BITS-1:0] bucket_size;

   logic                          wr_en, wr_bank;
   logic [CH_BITS-1:0]            wr_chan;
   logic signed [SAMPLE_BITS-1:0] wr_min, wr_max;
   logic                          upd_rd_en, upd_rd_bank;
   logic [CH_BITS-1:0]            upd_rd_chan;
   logic signed [SAMPLE_BITS-1:0] upd_rd_min, upd_rd_max;
   logic                          drn_rd_en, drn_rd_bank;
   logic [CH_BITS-1:0]            drn_rd_chan;
   logic [1:0]                    bank_busy;
   close_event_type               close_event;
   bank_clear_type                bank_clear;

   // Register writes; the low address bits select byte lanes and are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[2]);

   always_comb begin
      channel_count_in = channel_count_ff;
      bucket_reg_in    = bucket_reg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CHANNEL_COUNT: begin
               channel_count_in = csr_pwdata[COUNT_REG_BITS-1:0];
            end
            REG_SAMPLES_PER_BUCKET: begin
               bucket_reg_in = csr_pwdata[BUCKET_REG_BITS-1:0];
            end
            default: begin
               channel_count_in = channel_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_count_ff <= CHANNEL_COUNT_RESET;
         bucket_reg_ff    <= BUCKET_SIZE_RESET;
      end else begin
         channel_count_ff <= channel_count_in;
         bucket_reg_ff    <= bucket_reg_in;
      end
   end

   // Register read-back.
   always_comb begin
      case (csr_index)
         REG_CHANNEL_COUNT:      csr_prdata = CSR_DATA_BITS'(channel_count_ff);
         REG_SAMPLES_PER_BUCKET: csr_prdata = CSR_DATA_BITS'(bucket_reg_ff);
         default:                csr_prdata = '0;
      endcase
   end

   // A zero channel count means one channel; too many saturate.
   always_comb begin
      if (channel_count_ff == '0) begin
         active_count = CNT_BITS'(1);
      end else if (32'(channel_count_ff) > 32'(MAX_CHANNELS)) begin
         active_count = CNT_BITS'(MAX_CHANNELS);
      end else begin
         active_count = CNT_BITS'(channel_count_ff);
      end
   end

   // A zero bucket size means one frame per bucket.
   assign bucket_size = (bucket_reg_ff == '0) ? BUCKET_REG_BITS'(1) : bucket_reg_ff;

   wme_update #(
      .MAX_CHANNELS     (MAX_CHANNELS),
      .SAMPLE_BITS      (SAMPLE_BITS),
      .FRAME_COUNT_BITS (FRAME_COUNT_BITS)
   ) u_update (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .req_last_sample (req_last_sample),
      .active_count    (active_count),
      .bucket_size     (bucket_size),
      .bank_busy       (bank_busy),
      .wr_en           (wr_en),
      .wr_bank         (wr_bank),
      .wr_chan         (wr_chan),
      .wr_min          (wr_min),
      .wr_max          (wr_max),
      .rd_en           (upd_rd_en),
      .rd_bank         (upd_rd_bank),
      .rd_chan         (upd_rd_chan),
      .rd_min          (upd_rd_min),
      .rd_max          (upd_rd_max),
      .close_event     (close_event)
   );

   wme_store #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_bank     (wr_bank),
      .wr_chan     (wr_chan),
      .wr_min      (wr_min),
      .wr_max      (wr_max),
      .upd_rd_en   (upd_rd_en),
      .upd_rd_bank (upd_rd_bank),
      .upd_rd_chan (upd_rd_chan),
      .upd_rd_min  (upd_rd_min),
      .upd_rd_max  (upd_rd_max),
      .drn_rd_en   (drn_rd_en),
      .drn_rd_bank (drn_rd_bank),
      .drn_rd_chan (drn_rd_chan),
      .drn_rd_min  (rsp_min_value),
      .drn_rd_max  (rsp_max_value),
      .bank_clear  (bank_clear)
   );

   wme_drain #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_drain (
      .clock                  (clock),
      .reset                  (reset),
      .close_event            (close_event),
      .active_count           (active_count),
      .bank_busy              (bank_busy),
      .rd_en                  (drn_rd_en),
      .rd_bank                (drn_rd_bank),
      .rd_chan                (drn_rd_chan),
      .bank_clear             (bank_clear),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_channel            (rsp_channel),
      .rsp_bucket_start_frame (rsp_bucket_start_frame),
      .rsp_last_of_run        (rsp_last_of_run),
      .rsp_end_of_stream      (rsp_end_of_stream)
   );

endmodule

// ----- sv/wme_store.sv -----
// Accumulator store: a two-bank min/max memory with one write port and two
// registered read ports, plus a seen bit per entry so a bank clears at once.
// Depends on wme_pkg.
module wme_store #(
   parameter int MAX_CHANNELS = 8,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                               clock,
   input  logic                                               reset,
   // Write port from the read-modify-write stage.
   input  logic                                               wr_en,
   input  logic                                               wr_bank,
   input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] wr_chan,
   input  logic signed [SAMPLE_BITS-1:0]                      wr_min,
   input  logic signed [SAMPLE_BITS-1:0]                      wr_max,
   // Read port for the update path.
   input  logic                                               upd_rd_en,
   input  logic                                               upd_rd_bank,
   input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] upd_rd_chan,
   output logic signed [SAMPLE_BITS-1:0]                      upd_rd_min,
   output logic signed [SAMPLE_BITS-1:0]                      upd_rd_max,
   // Read port for the drain path; its data register is the result payload.
   input  logic                                               drn_rd_en,
   input  logic                                               drn_rd_bank,
   input  logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] drn_rd_chan,
   output logic signed [SAMPLE_BITS-1:0]                      drn_rd_min,
   output logic signed [SAMPLE_BITS-1:0]                      drn_rd_max,
   // Bank clear from the drain.
   input  wme_pkg::bank_clear_type                            bank_clear
);
   import wme_pkg::*;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // Each word holds {min, max}.
   logic [2*SAMPLE_BITS-1:0] mem [2][MAX_CHANNELS];

   logic [2*SAMPLE_BITS-1:0] upd_word_ff;
   logic [2*SAMPLE_BITS-1:0] drn_word_ff;
   logic                     upd_seen_ff;
   logic                     drn_seen_ff;
   logic [MAX_CHANNELS-1:0]  seen_ff [2];
   logic [MAX_CHANNELS-1:0]  seen_in [2];

   // Memory write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_bank][wr_chan] <= {wr_min, wr_max};
      end
   end

   // Registered read ports; the seen bit is captured with the data.
   always_ff @(posedge clock) begin
      if (upd_rd_en) begin
         upd_word_ff <= mem[upd_rd_bank][upd_rd_chan];
         upd_seen_ff <= seen_ff[upd_rd_bank][upd_rd_chan];
      end
      if (drn_rd_en) begin
         drn_word_ff <= mem[drn_rd_bank][drn_rd_chan];
         drn_seen_ff <= seen_ff[drn_rd_bank][drn_rd_chan];
      end
   end

   // Seen bits: cleared a whole bank at a time, set by each write.
   always_comb begin
      seen_in = seen_ff;
      if (bank_clear.clear) begin
         seen_in[bank_clear.bank] = '0;
      end
      if (wr_en) begin
         seen_in[wr_bank][wr_chan] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff[0] <= '0;
         seen_ff[1] <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // An entry not written since its bank was cleared reads as the start values.
   assign upd_rd_min = upd_seen_ff ? upd_word_ff[2*SAMPLE_BITS-1:SAMPLE_BITS] : SAMPLE_TOP;
   assign upd_rd_max = upd_seen_ff ? upd_word_ff[SAMPLE_BITS-1:0] : SAMPLE_BOTTOM;
   assign drn_rd_min = drn_seen_ff ? drn_word_ff[2*SAMPLE_BITS-1:SAMPLE_BITS] : SAMPLE_TOP;
   assign drn_rd_max = drn_seen_ff ? drn_word_ff[SAMPLE_BITS-1:0] : SAMPLE_BOTTOM;

endmodule

// ----- sv/wme_update.sv -----
// Input side: tracks channel position, frame count and bucket start, reads
// the accumulator entry and writes back the new min/max in the following cycle.
// Depends on wme_pkg; drives the write and update read ports of wme_store.
module wme_update #(
   parameter int MAX_CHANNELS     = 8,
   parameter int SAMPLE_BITS      = 16,
   parameter int FRAME_COUNT_BITS = 32
) (
   input  logic                                               clock,
   input  logic                                               reset,
   // Request channel.
   input  logic                                               req_valid,
   output logic                                               req_stall,
   input  logic signed [SAMPLE_BITS-1:0]                      req_sample,
   input  logic                                               req_last_sample,
   // Settings already cleaned up by the top level.
   input  logic [$clog2(MAX_CHANNELS+1)-1:0]                  active_count,
   input  logic [wme_pkg::BUCKET_REG_BITS-1:0]                bucket_size,
   input  logic [1:0]                                         bank_busy,
   // Store ports.
   output logic                                               wr_en,
   output logic                                               wr_bank,
   output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] wr_chan,
   output logic signed [SAMPLE_BITS-1:0]                      wr_min,
   output logic signed [SAMPLE_BITS-1:0]                      wr_max,
   output logic                                               rd_en,
   output logic                                               rd_bank,
   output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_chan,
   input  logic signed [SAMPLE_BITS-1:0]                      rd_min,
   input  logic signed [SAMPLE_BITS-1:0]                      rd_max,
   // Bucket close towards the drain.
   output wme_pkg::close_event_type                           close_event
);
   import wme_pkg::*;

   localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_BITS = $clog2(MAX_CHANNELS+1);

   // Stream position state, advanced at each accepted request.
   logic [CH_BITS-1:0]          position_ff, position_in;
   logic [BUCKET_REG_BITS-1:0]  frames_ff, frames_in;
   logic [FRAME_COUNT_BITS-1:0] first_frame_ff, first_frame_in;
   logic                        acc_bank_ff, acc_bank_in;

   // Read-modify-write stage.
   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_bank_ff;
   logic [CH_BITS-1:0]            s1_chan_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_close_ff, s1_close_in;
   logic                          s1_eos_ff;
   logic [OUT_FRAME_BITS-1:0]     s1_frame_ff;
   logic                          fwd_hit_ff, fwd_hit_in;
   logic signed [SAMPLE_BITS-1:0] fwd_min_ff;
   logic signed [SAMPLE_BITS-1:0] fwd_max_ff;

   logic                          accept;
   logic [CH_BITS-1:0]            pos;
   logic [CNT_BITS-1:0]           pos_next;
   logic                          frame_done;
   logic                          bucket_done;
   logic [BUCKET_REG_BITS:0]      frames_next;
   logic signed [SAMPLE_BITS-1:0] old_min, old_max, new_min, new_max;

   // A bank still being drained cannot take a new bucket.
   assign req_stall = bank_busy[acc_bank_ff];
   assign accept    = req_valid && !req_stall;

   // Position, clamped when the channel count has been lowered mid-frame.
   always_comb begin
      if (CNT_BITS'(position_ff) >= active_count) begin
         pos = CH_BITS'(active_count - CNT_BITS'(1));
      end else begin
         pos = position_ff;
      end
      pos_next    = CNT_BITS'(pos) + CNT_BITS'(1);
      frame_done  = (pos_next >= active_count) || req_last_sample;
      frames_next = {1'b0, frames_ff} + (BUCKET_REG_BITS+1)'(1);
      bucket_done = frame_done &&
                    ((frames_next >= {1'b0, bucket_size}) || req_last_sample);
   end

   // Next stream state.
   always_comb begin
      position_in    = position_ff;
      frames_in      = frames_ff;
      first_frame_in = first_frame_ff;
      acc_bank_in    = acc_bank_ff;
      if (accept) begin
         if (frame_done) begin
            position_in = '0;
         end else begin
            position_in = CH_BITS'(pos_next);
         end
         if (bucket_done) begin
            frames_in   = '0;
            acc_bank_in = ~acc_bank_ff;
            if (req_last_sample) begin
               first_frame_in = '0;
            end else begin
               first_frame_in = first_frame_ff + FRAME_COUNT_BITS'(frames_next);
            end
         end else if (frame_done) begin
            frames_in = frames_next[BUCKET_REG_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff    <= '0;
         frames_ff      <= '0;
         first_frame_ff <= '0;
         acc_bank_ff    <= 1'b0;
      end else begin
         position_ff    <= position_in;
         frames_ff      <= frames_in;
         first_frame_ff <= first_frame_in;
         acc_bank_ff    <= acc_bank_in;
      end
   end

   // Read the entry as the request is accepted.
   assign rd_en   = accept;
   assign rd_bank = acc_bank_ff;
   assign rd_chan = pos;

   // The previous request may be writing this entry in the same cycle.
   always_comb begin
      old_min = fwd_hit_ff ? fwd_min_ff : rd_min;
      old_max = fwd_hit_ff ? fwd_max_ff : rd_max;
      new_min = (s1_sample_ff < old_min) ? s1_sample_ff : old_min;
      new_max = (s1_sample_ff > old_max) ? s1_sample_ff : old_max;
   end

   assign s1_valid_in = accept;
   assign s1_close_in = accept && bucket_done;
   assign fwd_hit_in  = s1_valid_ff && (s1_bank_ff == acc_bank_ff) && (s1_chan_ff == pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_close_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_close_ff <= s1_close_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_bank_ff   <= acc_bank_ff;
         s1_chan_ff   <= pos;
         s1_sample_ff <= req_sample;
         s1_eos_ff    <= req_last_sample;
         s1_frame_ff  <= OUT_FRAME_BITS'(first_frame_ff);
         fwd_hit_ff   <= fwd_hit_in;
         fwd_min_ff   <= new_min;
         fwd_max_ff   <= new_max;
      end
   end

   // Write back.
   assign wr_en   = s1_valid_ff;
   assign wr_bank = s1_bank_ff;
   assign wr_chan = s1_chan_ff;
   assign wr_min  = new_min;
   assign wr_max  = new_max;

   // The closing request's write lands at this edge, so the drain may start next.
   always_comb begin
      close_event.valid = s1_valid_ff && s1_close_ff;
      close_event.bank  = s1_bank_ff;
      close_event.eos   = s1_eos_ff;
      close_event.frame = s1_frame_ff;
   end

endmodule

// ----- sv/wme_drain.sv -----
// Result side: walks the channels of each closed bank through the store's
// drain read port, one result a cycle while rsp_stall is low, then releases the bank.
// Depends on wme_pkg; drives the drain read port of wme_store.
module wme_drain #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  wme_pkg::close_event_type                           close_event,
   input  logic [$clog2(MAX_CHANNELS+1)-1:0]                  active_count,
   output logic [1:0]                                         bank_busy,
   // Store drain read port.
   output logic                                               rd_en,
   output logic                                               rd_bank,
   output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] rd_chan,
   output wme_pkg::bank_clear_type                            bank_clear,
   // Result channel, less the min/max payload that comes from the store.
   output logic                                               rsp_valid,
   input  logic                                               rsp_stall,
   output logic [wme_pkg::OUT_CHAN_BITS-1:0]                  rsp_channel,
   output logic [wme_pkg::OUT_FRAME_BITS-1:0]                 rsp_bucket_start_frame,
   output logic                                               rsp_last_of_run,
   output logic                                               rsp_end_of_stream
);
   import wme_pkg::*;

   localparam int CH_BITS  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CNT_BITS = $clog2(MAX_CHANNELS+1);

   logic [1:0]                busy_ff, busy_in;
   logic                      drain_bank_ff, drain_bank_in;
   logic [CH_BITS-1:0]        chan_ff, chan_in;
   logic [OUT_FRAME_BITS-1:0] meta_frame_ff [2];
   logic                      meta_eos_ff [2];

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CH_BITS-1:0]        rsp_chan_ff;
   logic [OUT_FRAME_BITS-1:0] rsp_frame_ff;
   logic                      rsp_last_ff;
   logic                      rsp_eos_ff;

   logic                      advance;
   logic                      issue;
   logic                      final_chan;

   // The store's read register doubles as the output register.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign issue      = busy_ff[drain_bank_ff] && advance;
   assign final_chan = (CNT_BITS'(chan_ff) + CNT_BITS'(1)) >= active_count;

   assign rd_en   = issue;
   assign rd_bank = drain_bank_ff;
   assign rd_chan = chan_ff;

   // Bank bookkeeping: set on close, released after its last channel.
   always_comb begin
      busy_in          = busy_ff;
      drain_bank_in    = drain_bank_ff;
      chan_in          = chan_ff;
      bank_clear.clear = 1'b0;
      bank_clear.bank  = drain_bank_ff;
      if (close_event.valid) begin
         busy_in[close_event.bank] = 1'b1;
      end
      if (issue) begin
         if (final_chan) begin
            chan_in                = '0;
            busy_in[drain_bank_ff] = 1'b0;
            drain_bank_in          = ~drain_bank_ff;
            bank_clear.clear       = 1'b1;
         end else begin
            chan_in = chan_ff + CH_BITS'(1);
         end
      end
   end

   assign rsp_valid_in = issue || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= '0;
         drain_bank_ff <= 1'b0;
         chan_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         drain_bank_ff <= drain_bank_in;
         chan_ff       <= chan_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Per-bank start frame and end-of-stream flag, captured at close.
   always_ff @(posedge clock) begin
      if (close_event.valid) begin
         meta_frame_ff[close_event.bank] <= close_event.frame;
         meta_eos_ff[close_event.bank]   <= close_event.eos;
      end
   end

   // Result sideband, loaded together with the store read.
   always_ff @(posedge clock) begin
      if (issue) begin
         rsp_chan_ff  <= chan_ff;
         rsp_frame_ff <= meta_frame_ff[drain_bank_ff];
         rsp_last_ff  <= final_chan;
         rsp_eos_ff   <= meta_eos_ff[drain_bank_ff];
      end
   end

   assign bank_busy              = busy_ff;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_channel            = OUT_CHAN_BITS'(rsp_chan_ff);
   assign rsp_bucket_start_frame = rsp_frame_ff;
   assign rsp_last_of_run        = rsp_last_ff;
   assign rsp_end_of_stream      = rsp_eos_ff;

endmodule

// ----- verif/waveform_minmax_envelope_tb.sv -----
// Self-checking testbench for the min/max peak envelope block.
// It drives requests and register writes, predicts the per-channel envelope
// results and checks them in order. Depends on wme_pkg and the RTL only.
module waveform_minmax_envelope_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wme_pkg::*;

   localparam int CHANNELS_MAX = 8;
   localparam int RUN_LIMIT    = 400000;
   localparam int SETTLE       = 8;

   // One expected envelope entry.
   typedef struct {
      logic [2:0]         channel;
      logic [31:0]        start_frame;
      logic signed [15:0] min_value;
      logic signed [15:0] max_value;
      logic               last_of_run;
      logic               end_of_stream;
   } envelope_entry_type;

   // Tracks the envelope state, queues the entries each request should cause
   // and checks the results against them in order.
   class envelope_checker_type;
      logic [3:0]         count_reg;
      logic [15:0]        bucket_reg;
      logic signed [15:0] low_seen [CHANNELS_MAX];
      logic signed [15:0] high_seen [CHANNELS_MAX];
      int unsigned        position;
      int unsigned        frames;
      logic [31:0]        first_frame;
      envelope_entry_type awaited[$];
      int                 errors;
      int                 checked;

      function new();
         count_reg   = CHANNEL_COUNT_RESET;
         bucket_reg  = BUCKET_SIZE_RESET;
         position    = 0;
         frames      = 0;
         first_frame = '0;
         errors      = 0;
         checked     = 0;
         clear_channels();
      endfunction

      function void clear_channels();
         for (int k = 0; k < CHANNELS_MAX; k++) begin
            low_seen[k]  = 16'sh7FFF;
            high_seen[k] = 16'sh8000;
         end
      endfunction

      // A zero count means one channel; counts above the maximum saturate.
      function int unsigned active_channels();
         if (count_reg == 0) return 1;
         if (count_reg > CHANNELS_MAX) return CHANNELS_MAX;
         return count_reg;
      endfunction

      function void write_register(csr_index_type idx, logic [31:0] value);
         if (idx == REG_CHANNEL_COUNT) count_reg = value[3:0];
         else bucket_reg = value[15:0];
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // Note an accepted request and queue whatever results it closes.
      function void take_sample(logic signed [15:0] sample, logic last);
         int unsigned        chans;
         int unsigned        pos;
         int unsigned        bucket;
         envelope_entry_type e;
         chans  = active_channels();
         bucket = (bucket_reg == 0) ? 1 : bucket_reg;
         pos    = position;
         // A position left past a lowered channel count lands on the last one.
         if (pos >= chans) pos = chans - 1;
         if (sample < low_seen[pos]) low_seen[pos] = sample;
         if (sample > high_seen[pos]) high_seen[pos] = sample;
         if (pos + 1 < chans && !last) begin
            position = pos + 1;
            return;
         end
         position = 0;
         frames++;
         if (frames < bucket && !last) return;
         for (int unsigned k = 0; k < chans; k++) begin
            e.channel       = k[2:0];
            e.start_frame   = first_frame;
            e.min_value     = low_seen[k];
            e.max_value     = high_seen[k];
            e.last_of_run   = (k + 1 == chans);
            e.end_of_stream = last;
            awaited = {awaited, e};
         end
         clear_channels();
         // The end of a stream restarts the frame count at zero.
         if (last) first_frame = '0;
         else first_frame = first_frame + frames;
         frames = 0;
      endfunction

      function void compare(string field, longint expected, longint actual);
         if (expected != actual) begin
            $error("%s: expected %0d, actual %0d", field, expected, actual);
            errors++;
         end
      endfunction

      function void check_envelope(envelope_entry_type got);
         envelope_entry_type want;
         if (awaited.size() == 0) begin
            $error("result for channel %0d arrived with nothing expected", got.channel);
            errors++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare("channel", want.channel, got.channel);
         compare("bucket_start_frame", want.start_frame, got.start_frame);
         compare("min_value", longint'(want.min_value), longint'(got.min_value));
         compare("max_value", longint'(want.max_value), longint'(got.max_value));
         compare("last_of_run", want.last_of_run, got.last_of_run);
         compare("end_of_stream", want.end_of_stream, got.end_of_stream);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic signed [15:0]       req_sample;
   logic                     req_last_sample;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [OUT_CHAN_BITS-1:0] rsp_channel;
   logic [31:0]              rsp_bucket_start_frame;
   logic signed [15:0]       rsp_min_value;
   logic signed [15:0]       rsp_max_value;
   logic                     rsp_last_of_run;
   logic                     rsp_end_of_stream;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   envelope_checker_type tracker = new();
   int                   send_idle_pct = 0;
   int                   recv_stall_pct = 0;
   int                   request_count = 0;
   int                   register_writes = 0;
   int                   csr_errors = 0;
   int                   cycle_count = 0;

   waveform_minmax_envelope dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_sample             (req_sample),
      .req_last_sample        (req_last_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_channel            (rsp_channel),
      .rsp_bucket_start_frame (rsp_bucket_start_frame),
      .rsp_min_value          (rsp_min_value),
      .rsp_max_value          (rsp_max_value),
      .rsp_last_of_run        (rsp_last_of_run),
      .rsp_end_of_stream      (rsp_end_of_stream),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Guard against a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // The receiver stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Check every accepted result against the oldest expectation.
   always @(posedge clock) begin
      envelope_entry_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.channel       = rsp_channel;
         got.start_frame   = rsp_bucket_start_frame;
         got.min_value     = rsp_min_value;
         got.max_value     = rsp_max_value;
         got.last_of_run   = rsp_last_of_run;
         got.end_of_stream = rsp_end_of_stream;
         tracker.check_envelope(got);
      end
   end

   // Send one request, idling first at the current rate, and wait for acceptance.
   task automatic send_sample(logic signed [15:0] sample, logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sample      <= sample;
      req_last_sample <= last;
      do @(posedge clock); while (req_stall);
      tracker.take_sample(sample, last);
      request_count++;
   endtask

   // Hold off requests until every expected result has come, then let the
   // pipeline settle so that a half-finished frame is not in flight.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.pending() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // One register access: a setup phase, then an access phase until ready.
   task automatic csr_access(csr_index_type idx, logic wr, logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Write a register, update the prediction and read the value back.
   task automatic program_register(csr_index_type idx, logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] field_mask;
      field_mask = (idx == REG_CHANNEL_COUNT) ? 32'h0000_000F : 32'h0000_FFFF;
      csr_access(idx, 1'b1, value, readback);
      tracker.write_register(idx, value);
      register_writes++;
      csr_access(idx, 1'b0, '0, readback);
      if (readback !== (value & field_mask)) begin
         $error("register %s: expected %0d, actual %0d", idx.name(),
                value & field_mask, readback);
         csr_errors++;
      end
   endtask

   // Random sample, weighted towards the full-scale values and zero.
   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // A run of streams under one setting. Most are whole frames closed by the
   // end flag; some end mid-frame, some carry on without it, and some are
   // followed by a pause until the results have drained.
   task automatic run_segment(logic [31:0] count_value, logic [31:0] bucket_value,
                              int budget);
      int sent;
      int total;
      int cut;
      int style;
      sent = 0;
      wait_drained();
      program_register(REG_CHANNEL_COUNT, count_value);
      program_register(REG_SAMPLES_PER_BUCKET, bucket_value);
      while (sent < budget) begin
         total = $urandom_range(1, 10) * tracker.active_channels();
         style = $urandom_range(0, 9);
         cut   = (style == 0) ? $urandom_range(0, total - 1) : total - 1;
         for (int i = 0; i <= cut; i++) begin
            send_sample(pick_sample(), (style != 1) && (i == cut));
            sent++;
         end
         if (style == 2) wait_drained();
      end
   endtask

   // Extreme settings, two per idling phase.
   logic [31:0] edge_counts  [6] = '{8, 1, 15, 0, 8, 1};
   logic [31:0] edge_buckets [6] = '{65535, 1, 0, 2, 1, 65535};

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_sample      = '0;
      req_last_sample = 1'b0;
      csr_psel        = 1'b0;
      csr_penable     = 1'b0;
      csr_pwrite      = 1'b0;
      csr_paddr       = '0;
      csr_pwdata      = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Full-scale samples in a two-channel, two-frame bucket.
      program_register(REG_CHANNEL_COUNT, 2);
      program_register(REG_SAMPLES_PER_BUCKET, 2);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      // Stream ends mid-frame: the unseen channel reports its starting values.
      send_sample(16'sh0000, 1'b1);

      // Zero channel count and zero bucket size both act as one.
      wait_drained();
      program_register(REG_CHANNEL_COUNT, 0);
      program_register(REG_SAMPLES_PER_BUCKET, 0);
      send_sample(16'sh1234, 1'b0);
      send_sample(16'shFFFF, 1'b0);
      send_sample(16'sh8001, 1'b1);

      // A count above the maximum saturates to eight channels.
      wait_drained();
      program_register(REG_CHANNEL_COUNT, 15);
      program_register(REG_SAMPLES_PER_BUCKET, 1);
      for (int k = 0; k < CHANNELS_MAX; k++) send_sample(pick_sample(), 1'b0);

      // Channel count lowered part-way through a frame closes that frame.
      wait_drained();
      program_register(REG_CHANNEL_COUNT, 8);
      program_register(REG_SAMPLES_PER_BUCKET, 3);
      for (int k = 0; k < 5; k++) send_sample(pick_sample(), 1'b0);
      wait_drained();
      program_register(REG_CHANNEL_COUNT, 3);
      send_sample(16'sh4000, 1'b1);

      // Random part under three idling patterns.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 17 : (phase == 1) ? 49 : 0;
         recv_stall_pct = (phase == 0) ? 49 : (phase == 1) ? 17 : 0;
         for (int seg = 0; seg < 4; seg++) begin
            if (seg < 2)
               run_segment(edge_counts[2*phase+seg], edge_buckets[2*phase+seg], 15);
            else
               run_segment($urandom_range(1, 8), $urandom_range(1, 6), 15);
         end
      end

      wait_drained();
      $display("summary: %0d requests sent, %0d results checked, %0d register writes",
               request_count, tracker.checked, register_writes);
      $display("summary: channel counts 0 to 15, bucket sizes 0 to 65535, three idling phases");
      if (tracker.errors == 0 && csr_errors == 0 && tracker.pending() == 0) begin
         $display("tb: success");
      end else begin
         if (tracker.pending() > 0) $error("%0d results never arrived", tracker.pending());
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/wme_pkg.sv
sv/wme_store.sv
sv/wme_update.sv
sv/wme_drain.sv
sv/waveform_minmax_envelope.sv
verif/waveform_minmax_envelope_tb.sv
